// ===== hdl/fdr_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the frame dirty-rectangle block.
// No dependencies; every module of the block imports this package.
package fdr_pkg;

  localparam int DEF_MAX_WIDTH  = 1024;
  localparam int DEF_MAX_HEIGHT = 1024;

  // Configuration port
  localparam int CFG_INDEX_W    = 8;
  localparam int CFG_DATA_W     = 11;
  localparam int CFG_RESET_SIZE = 1024;

  localparam logic [CFG_INDEX_W-1:0] REG_FRAME_WIDTH  = 8'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_FRAME_HEIGHT = 8'd1;

  // Payload widths
  localparam int PIX_W    = 16;
  localparam int BGR_W    = 15;
  localparam int LEFT_W   = 10;
  localparam int TOP_W    = 10;
  localparam int RIGHT_W  = 11;
  localparam int BOTTOM_W = 11;
  localparam int M_DATA_W = 64;

  // Position flags of one pixel
  typedef struct packed {
    logic first;  // column 0, row 0: clear the box first
    logic last;   // last pixel of the frame
  } pos_flags_t;

endpackage

// ===== hdl/fdr_position.sv =====
`timescale 1ns / 1ps
// Frame size registers and raster position counters.
// Depends on fdr_pkg.
module fdr_position #(
  parameter int MAX_WIDTH  = fdr_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = fdr_pkg::DEF_MAX_HEIGHT
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_write,
  input  logic [fdr_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [fdr_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  logic                               take,
  input  logic                               frame_start,
  output logic [$clog2(MAX_WIDTH)-1:0]       col,
  output logic [$clog2(MAX_HEIGHT)-1:0]      row,
  output fdr_pkg::pos_flags_t                flags
);
  import fdr_pkg::*;

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int RW = $clog2(MAX_HEIGHT);
  localparam int SWW = CW + 1;
  localparam int SWH = RW + 1;
  localparam int W_RST = (CFG_RESET_SIZE > MAX_WIDTH) ? MAX_WIDTH : CFG_RESET_SIZE;
  localparam int H_RST = (CFG_RESET_SIZE > MAX_HEIGHT) ? MAX_HEIGHT : CFG_RESET_SIZE;

  logic [SWW-1:0] width_lim;
  logic [SWH-1:0] height_lim;
  logic [SWW-1:0] width_clamp;
  logic [SWH-1:0] height_clamp;
  logic [CW-1:0]  col_count;
  logic [RW-1:0]  row_count;
  logic [CW-1:0]  col_count_next;
  logic [RW-1:0]  row_count_next;
  logic [SWW-1:0] col_inc;
  logic [SWH-1:0] row_inc;
  logic           last_col;
  logic           last_row;

  // Clamp written sizes into 1..MAX
  always_comb begin
    if (cfg_data == '0) begin
      width_clamp = SWW'(1);
    end else if (32'(cfg_data) > MAX_WIDTH) begin
      width_clamp = SWW'(MAX_WIDTH);
    end else begin
      width_clamp = SWW'(cfg_data);
    end
    if (cfg_data == '0) begin
      height_clamp = SWH'(1);
    end else if (32'(cfg_data) > MAX_HEIGHT) begin
      height_clamp = SWH'(MAX_HEIGHT);
    end else begin
      height_clamp = SWH'(cfg_data);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      width_lim  <= SWW'(W_RST);
      height_lim <= SWH'(H_RST);
    end else if (cfg_write) begin
      case (cfg_index)
        REG_FRAME_WIDTH:  width_lim  <= width_clamp;
        REG_FRAME_HEIGHT: height_lim <= height_clamp;
        default: ;
      endcase
    end
  end

  always_comb begin
    col      = frame_start ? '0 : col_count;
    row      = frame_start ? '0 : row_count;
    col_inc  = {1'b0, col} + SWW'(1);
    row_inc  = {1'b0, row} + SWH'(1);
    last_col = col_inc >= width_lim;
    last_row = row_inc >= height_lim;
    flags.first = (col == '0) && (row == '0);
    flags.last  = last_col && last_row;
    if (last_col) begin
      col_count_next = '0;
      row_count_next = last_row ? '0 : row_inc[RW-1:0];
    end else begin
      col_count_next = col_inc[CW-1:0];
      row_count_next = row;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col_count <= '0;
      row_count <= '0;
    end else if (take) begin
      col_count <= col_count_next;
      row_count <= row_count_next;
    end
  end

endmodule

// ===== hdl/fdr_store.sv =====
`timescale 1ns / 1ps
// Previous-frame store: single write port, registered read, write forwarding
// and the clearing sweep after reset. Depends on fdr_pkg.
module fdr_store #(
  parameter int AW = 20
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     rd_en,
  input  logic [AW-1:0]            rd_addr,
  input  logic                     s1_valid,
  input  logic                     wr_en,
  input  logic [AW-1:0]            wr_addr,
  input  logic [fdr_pkg::PIX_W-1:0] wr_data,
  output logic [fdr_pkg::PIX_W-1:0] prev_pixel,
  output logic                     busy
);
  import fdr_pkg::*;

  localparam int DEPTH = 1 << AW;

  logic [PIX_W-1:0] mem [DEPTH];
  logic [PIX_W-1:0] rd_data;
  logic [PIX_W-1:0] fwd_data;
  logic             fwd;
  logic [AW-1:0]    clr_addr;

  // Clear sweep, one entry per cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      busy     <= 1'b1;
      clr_addr <= '0;
    end else if (busy) begin
      clr_addr <= clr_addr + AW'(1);
      if (clr_addr == '1) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (busy) begin
      mem[clr_addr] <= '0;
    end else if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  // Bypass the write that lands on the same edge as the read
  always_ff @(posedge clk) begin
    if (rst) begin
      fwd <= 1'b0;
    end else if (rd_en) begin
      fwd <= s1_valid && (rd_addr == wr_addr);
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      fwd_data <= wr_data;
    end
  end

  assign prev_pixel = fwd ? fwd_data : rd_data;

  a_no_write_in_clear: assert property (@(posedge clk) disable iff (rst)
    busy |-> !wr_en) else $error("pixel write during clear sweep");
  a_no_read_in_clear: assert property (@(posedge clk) disable iff (rst)
    busy |-> !rd_en) else $error("pixel read during clear sweep");
  a_clear_ends: assert property (@(posedge clk) disable iff (rst)
    busy && (clr_addr == '1) |=> !busy) else $error("clear sweep overran");

endmodule

// ===== hdl/fdr_box.sv =====
`timescale 1ns / 1ps
// Compare stage, bounding-box tracking, pixel conversion and result register.
// Depends on fdr_pkg.
module fdr_box #(
  parameter int CW = 10,
  parameter int RW = 10
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         take,
  input  logic [fdr_pkg::PIX_W-1:0]    pixel,
  input  logic [CW-1:0]                col,
  input  logic [RW-1:0]                row,
  input  fdr_pkg::pos_flags_t          flags,
  input  logic [fdr_pkg::PIX_W-1:0]    prev_pixel,
  input  logic                         out_ready,
  output logic                         s1_valid,
  output logic                         advance,
  output logic [fdr_pkg::PIX_W-1:0]    s1_pixel,
  output logic [CW-1:0]                s1_col,
  output logic [RW-1:0]                s1_row,
  output logic                         out_valid,
  output logic [fdr_pkg::BGR_W-1:0]    out_bgr,
  output logic                         out_last,
  output logic                         out_changed,
  output logic [fdr_pkg::LEFT_W-1:0]   out_left,
  output logic [fdr_pkg::TOP_W-1:0]    out_top,
  output logic [fdr_pkg::RIGHT_W-1:0]  out_right,
  output logic [fdr_pkg::BOTTOM_W-1:0] out_bottom
);
  import fdr_pkg::*;

  pos_flags_t    s1_flags;
  logic          out_free;
  logic          any_difference;
  logic [CW-1:0] min_column;
  logic [CW-1:0] max_column;
  logic [RW-1:0] min_row;
  logic [RW-1:0] max_row;
  logic          any_difference_next;
  logic [CW-1:0] min_column_next;
  logic [CW-1:0] max_column_next;
  logic [RW-1:0] min_row_next;
  logic [RW-1:0] max_row_next;
  logic          diff;
  logic          report;
  logic [31:0]   left_full;
  logic [31:0]   top_full;
  logic [31:0]   right_full;
  logic [31:0]   bottom_full;

  assign out_free = !out_valid || out_ready;
  assign advance  = s1_valid && out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (take) begin
      s1_valid <= 1'b1;
    end else if (advance) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      s1_pixel <= pixel;
      s1_col   <= col;
      s1_row   <= row;
      s1_flags <= flags;
    end
  end

  always_comb begin
    diff = prev_pixel != s1_pixel;
    if (s1_flags.first) begin
      any_difference_next = 1'b0;
      min_column_next     = '0;
      max_column_next     = '0;
      min_row_next        = '0;
      max_row_next        = '0;
    end else begin
      any_difference_next = any_difference;
      min_column_next     = min_column;
      max_column_next     = max_column;
      min_row_next        = min_row;
      max_row_next        = max_row;
    end
    if (diff) begin
      if (!any_difference_next) begin
        min_column_next = s1_col;
        max_column_next = s1_col;
        min_row_next    = s1_row;
        max_row_next    = s1_row;
      end else begin
        if (s1_col < min_column_next) min_column_next = s1_col;
        if (s1_col > max_column_next) max_column_next = s1_col;
        if (s1_row < min_row_next) min_row_next = s1_row;
        if (s1_row > max_row_next) max_row_next = s1_row;
      end
      any_difference_next = 1'b1;
    end
    report      = s1_flags.last && any_difference_next;
    left_full   = 32'(min_column_next);
    top_full    = 32'(min_row_next);
    right_full  = 32'(max_column_next) + 32'd1;
    bottom_full = 32'(max_row_next) + 32'd1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      any_difference <= 1'b0;
      min_column     <= '0;
      max_column     <= '0;
      min_row        <= '0;
      max_row        <= '0;
    end else if (advance) begin
      any_difference <= any_difference_next;
      min_column     <= min_column_next;
      max_column     <= max_column_next;
      min_row        <= min_row_next;
      max_row        <= max_row_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= advance;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_bgr     <= {s1_pixel[4:0], s1_pixel[10:6], s1_pixel[15:11]};
      out_last    <= s1_flags.last;
      out_changed <= report;
      out_left    <= report ? left_full[LEFT_W-1:0] : '0;
      out_top     <= report ? top_full[TOP_W-1:0] : '0;
      out_right   <= report ? right_full[RIGHT_W-1:0] : '0;
      out_bottom  <= report ? bottom_full[BOTTOM_W-1:0] : '0;
    end
  end

  a_changed_at_end: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_changed |-> out_last) else $error("changed before frame end");
  a_quiet_box: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_changed |-> out_left == '0 && out_top == '0 &&
    out_right == '0 && out_bottom == '0) else $error("box set without change");
  a_stage_held: assert property (@(posedge clk) disable iff (rst)
    s1_valid && !advance |=> s1_valid) else $error("compare stage dropped an item");

endmodule

// ===== hdl/frame_dirty_rect_with_pixel_convert.sv =====
`timescale 1ns / 1ps
// Top level of the frame dirty-rectangle block with RGB565 to BGR555 convert.
// Depends on fdr_pkg, fdr_position, fdr_store and fdr_box.
//
//   Channel  Direction  Handshake            Payload
//   s_*      in         s_tvalid / s_tready  tdata pixel_in, tuser frame_start
//   m_*      out        m_tvalid / m_tready  tdata pixel and box, tlast, tuser
//   cfg_*    in         cfg_valid/cfg_ready  cfg_index, cfg_data
//
// One pixel per cycle sustained while m_tready stays high; a pixel's result passes
// the input and frame-store read registers, then the result register, before it
// is presented on m_*.
// After reset the frame store is swept to zero, one entry per cycle, over all
// 2**(clog2(MAX_WIDTH)+clog2(MAX_HEIGHT)) entries, 1048576 at the defaults.
// s_tready is low during the sweep; cfg writes are taken at all times.
// A stall on m_tready holds the result register; s_tready drops once the
// compare stage is also occupied.
module frame_dirty_rect_with_pixel_convert #(
  parameter int MAX_WIDTH  = fdr_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = fdr_pkg::DEF_MAX_HEIGHT
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  input  logic [fdr_pkg::PIX_W-1:0]       s_tdata,   // [15:0] pixel_in
  input  logic                            s_tuser,   // [0] frame_start
  output logic                            m_tvalid,
  input  logic                            m_tready,
  // [14:0] bgr_pixel, [24:15] left_edge, [34:25] top_edge,
  // [45:35] right_edge, [56:46] bottom_edge, [63:57] zero
  output logic [fdr_pkg::M_DATA_W-1:0]    m_tdata,
  output logic                            m_tlast,   // frame_end
  output logic                            m_tuser,   // [0] changed
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [fdr_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [fdr_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import fdr_pkg::*;

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int RW = $clog2(MAX_HEIGHT);
  localparam int AW = CW + RW;
  localparam int PAD_W = M_DATA_W - (BGR_W + LEFT_W + TOP_W + RIGHT_W + BOTTOM_W);

  logic                take;
  logic [CW-1:0]       col;
  logic [RW-1:0]       row;
  pos_flags_t          flags;
  logic                busy;
  logic                s1_valid;
  logic                advance;
  logic [PIX_W-1:0]    s1_pixel;
  logic [CW-1:0]       s1_col;
  logic [RW-1:0]       s1_row;
  logic [PIX_W-1:0]    prev_pixel;
  logic [BGR_W-1:0]    out_bgr;
  logic [LEFT_W-1:0]   out_left;
  logic [TOP_W-1:0]    out_top;
  logic [RIGHT_W-1:0]  out_right;
  logic [BOTTOM_W-1:0] out_bottom;

  assign cfg_ready = 1'b1;
  assign s_tready  = !busy && (!s1_valid || advance);
  assign take      = s_tvalid && s_tready;

  fdr_position #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_position (
    .clk         (clk),
    .rst         (rst),
    .cfg_write   (cfg_valid && cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .take        (take),
    .frame_start (s_tuser),
    .col         (col),
    .row         (row),
    .flags       (flags)
  );

  fdr_store #(
    .AW (AW)
  ) u_store (
    .clk        (clk),
    .rst        (rst),
    .rd_en      (take),
    .rd_addr    ({row, col}),
    .s1_valid   (s1_valid),
    .wr_en      (advance),
    .wr_addr    ({s1_row, s1_col}),
    .wr_data    (s1_pixel),
    .prev_pixel (prev_pixel),
    .busy       (busy)
  );

  fdr_box #(
    .CW (CW),
    .RW (RW)
  ) u_box (
    .clk         (clk),
    .rst         (rst),
    .take        (take),
    .pixel       (s_tdata),
    .col         (col),
    .row         (row),
    .flags       (flags),
    .prev_pixel  (prev_pixel),
    .out_ready   (m_tready),
    .s1_valid    (s1_valid),
    .advance     (advance),
    .s1_pixel    (s1_pixel),
    .s1_col      (s1_col),
    .s1_row      (s1_row),
    .out_valid   (m_tvalid),
    .out_bgr     (out_bgr),
    .out_last    (m_tlast),
    .out_changed (m_tuser),
    .out_left    (out_left),
    .out_top     (out_top),
    .out_right   (out_right),
    .out_bottom  (out_bottom)
  );

  assign m_tdata = {{PAD_W{1'b0}}, out_bottom, out_right, out_top, out_left, out_bgr};

endmodule

// ===== tb/sv/fdr_rect_checker.sv =====
`timescale 1ns / 1ps
// Scoreboard for the frame dirty-rectangle block: watches the pixel, result and
// register channels, predicts each converted pixel and frame report, compares.
// Depends on fdr_pkg for register indexes and field widths.
module fdr_rect_checker (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  input  logic                            s_tready,
  input  logic [fdr_pkg::PIX_W-1:0]       s_tdata,
  input  logic                            s_tuser,
  input  logic                            m_tvalid,
  input  logic                            m_tready,
  input  logic [fdr_pkg::M_DATA_W-1:0]    m_tdata,
  input  logic                            m_tlast,
  input  logic                            m_tuser,
  input  logic                            cfg_valid,
  input  logic                            cfg_ready,
  input  logic [fdr_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [fdr_pkg::CFG_DATA_W-1:0]  cfg_data,
  output int                              fail_count,
  output int                              results_due
);
  import fdr_pkg::*;

  localparam int MAX_W = DEF_MAX_WIDTH;
  localparam int MAX_H = DEF_MAX_HEIGHT;

  typedef struct packed {
    logic [BGR_W-1:0]    bgr_pixel;
    logic                frame_end;
    logic                changed;
    logic [LEFT_W-1:0]   left_edge;
    logic [TOP_W-1:0]    top_edge;
    logic [RIGHT_W-1:0]  right_edge;
    logic [BOTTOM_W-1:0] bottom_edge;
    logic [6:0]          pad;
  } frame_result_t;

  logic [PIX_W-1:0]      prior_frame [int];
  logic [CFG_DATA_W-1:0] frame_w;
  logic [CFG_DATA_W-1:0] frame_h;
  int                    col_cnt;
  int                    row_cnt;
  int                    min_col;
  int                    max_col;
  int                    min_row;
  int                    max_row;
  bit                    dirty;
  frame_result_t         pending_results [$];

  initial begin
    fail_count  = 0;
    results_due = 0;
  end

  task automatic predict_pixel(input logic [PIX_W-1:0] pix, input logic start_bit,
                               output frame_result_t res);
    int               w;
    int               h;
    int               col;
    int               row;
    int               addr;
    logic [PIX_W-1:0] stored;
    bit               last_col;
    bit               last_row;
    bit               done;
    w = (frame_w == 0) ? 1 : ((frame_w > MAX_W) ? MAX_W : int'(frame_w));
    h = (frame_h == 0) ? 1 : ((frame_h > MAX_H) ? MAX_H : int'(frame_h));
    if (start_bit) begin
      col_cnt = 0;
      row_cnt = 0;
    end
    col = col_cnt;
    row = row_cnt;
    if (col == 0 && row == 0) begin
      dirty   = 1'b0;
      min_col = 0;
      max_col = 0;
      min_row = 0;
      max_row = 0;
    end
    addr   = row * MAX_W + col;
    stored = prior_frame.exists(addr) ? prior_frame[addr] : '0;
    if (stored != pix) begin
      if (!dirty) begin
        min_col = col;
        max_col = col;
        min_row = row;
        max_row = row;
        dirty   = 1'b1;
      end else begin
        if (col < min_col) min_col = col;
        if (col > max_col) max_col = col;
        if (row < min_row) min_row = row;
        if (row > max_row) max_row = row;
      end
    end
    prior_frame[addr] = pix;
    last_col = (col + 1 >= w);
    last_row = (row + 1 >= h);
    done     = last_col && last_row;
    if (!last_col) begin
      col_cnt = col + 1;
    end else begin
      col_cnt = 0;
      row_cnt = last_row ? 0 : row + 1;
    end
    res           = '0;
    res.bgr_pixel = {pix[4:0], pix[10:6], pix[15:11]};
    res.frame_end = done;
    if (done && dirty) begin
      res.changed     = 1'b1;
      res.left_edge   = LEFT_W'(min_col);
      res.top_edge    = TOP_W'(min_row);
      res.right_edge  = RIGHT_W'(max_col + 1);
      res.bottom_edge = BOTTOM_W'(max_row + 1);
    end
  endtask

  task automatic check_field(input string name, input longint want_v, input longint got_v);
    if (want_v != got_v) begin
      $error("%s: expected 0x%0h, actual 0x%0h", name, want_v, got_v);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    frame_result_t want;
    frame_result_t got;
    if (rst) begin
      prior_frame.delete();
      pending_results.delete();
      frame_w = CFG_DATA_W'(CFG_RESET_SIZE);
      frame_h = CFG_DATA_W'(CFG_RESET_SIZE);
      col_cnt = 0;
      row_cnt = 0;
      min_col = 0;
      max_col = 0;
      min_row = 0;
      max_row = 0;
      dirty   = 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_FRAME_WIDTH:  frame_w = cfg_data;
          REG_FRAME_HEIGHT: frame_h = cfg_data;
          default: ;
        endcase
      end
      if (m_tvalid && m_tready) begin
        got             = '0;
        got.bgr_pixel   = m_tdata[14:0];
        got.left_edge   = m_tdata[24:15];
        got.top_edge    = m_tdata[34:25];
        got.right_edge  = m_tdata[45:35];
        got.bottom_edge = m_tdata[56:46];
        got.pad         = m_tdata[63:57];
        got.frame_end   = m_tlast;
        got.changed     = m_tuser;
        if (pending_results.size() == 0) begin
          $error("result transfer with no pixel outstanding: tdata 0x%0h", m_tdata);
          fail_count++;
        end else begin
          want = pending_results.pop_front();
          check_field("bgr_pixel", want.bgr_pixel, got.bgr_pixel);
          check_field("frame_end", want.frame_end, got.frame_end);
          check_field("changed", want.changed, got.changed);
          check_field("left_edge", want.left_edge, got.left_edge);
          check_field("top_edge", want.top_edge, got.top_edge);
          check_field("right_edge", want.right_edge, got.right_edge);
          check_field("bottom_edge", want.bottom_edge, got.bottom_edge);
          check_field("tdata_pad", want.pad, got.pad);
        end
      end
      if (s_tvalid && s_tready) begin
        predict_pixel(s_tdata, s_tuser, want);
        pending_results.push_back(want);
      end
    end
    results_due = pending_results.size();
  end

endmodule

// ===== tb/sv/frame_dirty_rect_with_pixel_convert_tb.sv =====
`timescale 1ns / 1ps
// Top of the frame dirty-rectangle testbench: drives pixel frames and size
// registers into the block and reports the verdict from fdr_rect_checker.
// Depends on fdr_pkg, the block and fdr_rect_checker.
module frame_dirty_rect_with_pixel_convert_tb;
  import fdr_pkg::*;

  localparam int CYCLE_LIMIT   = 3_000_000;
  localparam int RANDOM_PIXELS = 200;

  logic                   clk         = 1'b0;
  logic                   rst         = 1'b1;
  logic                   s_tvalid    = 1'b0;
  logic                   s_tready;
  logic [PIX_W-1:0]       s_tdata     = '0;
  logic                   s_tuser     = 1'b0;
  logic                   m_tvalid;
  logic                   m_tready    = 1'b0;
  logic [M_DATA_W-1:0]    m_tdata;
  logic                   m_tlast;
  logic                   m_tuser;
  logic                   cfg_valid   = 1'b0;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index   = '0;
  logic [CFG_DATA_W-1:0]  cfg_data    = '0;
  int                     fail_count;
  int                     results_due;
  int                     cycle_count = 0;
  bit                     idle_on     = 1'b1;
  int                     size_w      = CFG_RESET_SIZE;
  int                     size_h      = CFG_RESET_SIZE;
  int                     pixels_sent = 0;
  int                     phase_count = 0;

  frame_dirty_rect_with_pixel_convert i_dut (.*);

  fdr_rect_checker i_checker (.*);

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  always @(posedge clk) begin
    m_tready <= !idle_on || ($urandom_range(99) >= 9);
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  function automatic int eff_size(logic [CFG_DATA_W-1:0] v, int maxv);
    return (v == 0) ? 1 : ((v > maxv) ? maxv : int'(v));
  endfunction

  function automatic logic [CFG_DATA_W-1:0] pick_size(int upper);
    return ($urandom_range(15) == 0) ? '0 : CFG_DATA_W'($urandom_range(1, upper));
  endfunction

  function automatic logic [PIX_W-1:0] scene_pixel(int k, int rate);
    if ($urandom_range(99) < rate) return PIX_W'($urandom);
    return PIX_W'(k * 40503 + 4660);
  endfunction

  task automatic send_pixel(input logic [PIX_W-1:0] pix, input logic start_bit);
    if (idle_on) begin
      while ($urandom_range(99) < 9) begin
        s_tvalid <= 1'b0;
        @(posedge clk);
      end
    end
    s_tvalid <= 1'b1;
    s_tdata  <= pix;
    s_tuser  <= start_bit;
    do @(posedge clk); while (!s_tready);
    pixels_sent++;
  endtask

  task automatic send_frame(input int npix, input bit mark_start, input int rate);
    for (int k = 0; k < npix; k++) begin
      send_pixel(scene_pixel(k, rate), mark_start && k == 0);
    end
  endtask

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == REG_FRAME_WIDTH) size_w = eff_size(val, DEF_MAX_WIDTH);
    else size_h = eff_size(val, DEF_MAX_HEIGHT);
    @(posedge clk);
  endtask

  // Hold the pixel stream until every outstanding result has transferred.
  task automatic drain();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (results_due != 0);
    repeat (4) @(posedge clk);
  endtask

  // {frame_start, pixel}: quiet frame, extremes, dropped partial, one-pixel change
  logic [PIX_W:0] directed [20] = '{
    {1'b1, 16'h0000}, {1'b0, 16'h0000}, {1'b0, 16'h0000},
    {1'b0, 16'h0000}, {1'b0, 16'h0000}, {1'b0, 16'h0000},
    {1'b1, 16'hFFFF}, {1'b0, 16'hF800}, {1'b0, 16'h07E0},
    {1'b0, 16'h001F}, {1'b0, 16'h0020}, {1'b0, 16'h0000},
    {1'b1, 16'hFFFF}, {1'b0, 16'h1234},
    {1'b1, 16'hFFFF}, {1'b0, 16'h1234}, {1'b0, 16'h07E0},
    {1'b0, 16'h001F}, {1'b0, 16'h8001}, {1'b0, 16'h0000}
  };

  initial begin
    int random_sent;
    int npix;
    int rate;
    random_sent = 0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    write_reg(REG_FRAME_WIDTH, 11'd3);
    write_reg(REG_FRAME_HEIGHT, 11'd2);
    foreach (directed[i]) send_pixel(directed[i][PIX_W-1:0], directed[i][PIX_W]);
    // shrink the row width while the column count is past it
    send_pixel(16'h5A5A, 1'b1);
    send_pixel(16'hA5A5, 1'b0);
    drain();
    write_reg(REG_FRAME_WIDTH, 11'd1);
    send_pixel(16'h7FFF, 1'b0);
    send_pixel(16'h8000, 1'b0);
    drain();

    // widest row, clamped and zero sizes, no idling
    idle_on = 1'b0;
    write_reg(REG_FRAME_WIDTH, 11'd2047);
    write_reg(REG_FRAME_HEIGHT, 11'd0);
    send_frame(size_w * size_h, 1'b1, 100);
    drain();
    idle_on = 1'b1;

    while (random_sent < RANDOM_PIXELS) begin
      drain();
      if ($urandom_range(2) == 0) write_reg(REG_FRAME_WIDTH, pick_size(12));
      if ($urandom_range(2) == 0) write_reg(REG_FRAME_HEIGHT, pick_size(6));
      phase_count++;
      repeat ($urandom_range(1, 3)) begin
        npix = size_w * size_h;
        if ($urandom_range(9) == 0) npix = $urandom_range(1, npix);
        case ($urandom_range(2))
          0: rate = 0;
          1: rate = 3;
          default: rate = 30;
        endcase
        send_frame(npix, $urandom_range(19) != 0, rate);
        random_sent += npix;
      end
    end
    drain();
    repeat (8) @(posedge clk);

    $display("Streamed %0d pixels over %0d random size phases plus directed frames,",
             pixels_sent, phase_count);
    $display("including a full-width row frame with clamped and zero sizes.");
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// ===== frame_dirty_rect_with_pixel_convert.f =====
hdl/fdr_pkg.sv
hdl/fdr_position.sv
hdl/fdr_store.sv
hdl/fdr_box.sv
hdl/frame_dirty_rect_with_pixel_convert.sv
tb/sv/fdr_rect_checker.sv
tb/sv/frame_dirty_rect_with_pixel_convert_tb.sv
